// File: design/wsp_pkg.sv
// ----------------------------------------------------------------------------
// Watch slot pool package
// Shared widths, command and status codes, and cell control types.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int POOL_SIZE_DEF = 32;
    localparam int CMD_W         = 2;
    localparam int NUM_W         = 5;
    localparam int VAL_W         = 32;
    localparam int STAT_W        = 2;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 40;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NONE    = 2'd3;

    // Operations of the in-use list cells.
    localparam logic [1:0] UOP_HOLD = 2'd0;
    localparam logic [1:0] UOP_LOAD = 2'd1;
    localparam logic [1:0] UOP_ROT  = 2'd2;
    localparam logic [1:0] UOP_DROP = 2'd3;

    // Operations of the free stack cells.
    localparam logic [1:0] FOP_HOLD = 2'd0;
    localparam logic [1:0] FOP_POP  = 2'd1;
    localparam logic [1:0] FOP_PUSH = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [VAL_W-1:0] value;
    } wsp_uctl_t;

    typedef struct packed {
        logic [1:0] op;
    } wsp_fctl_t;

endpackage

// File: design/wsp_use_cell.sv
// ----------------------------------------------------------------------------
// In-use list cell
// Holds one in-use slot and its value. Cells form a ring whose length is the
// in-use count; the head leaves at cell 0 and may re-enter at the tail.
// ----------------------------------------------------------------------------
module wsp_use_cell #(
    parameter int SLOT_W = 5,
    parameter int CNT_W  = 6,
    parameter int IDX    = 0
) (
    input  logic                       aclk,
    input  wsp_pkg::wsp_uctl_t         ctrl,
    input  logic [CNT_W-1:0]           len,
    input  logic [SLOT_W-1:0]          load_slot,
    input  logic [SLOT_W-1:0]          next_slot,
    input  logic [wsp_pkg::VAL_W-1:0]  next_value,
    input  logic [SLOT_W-1:0]          head_slot,
    input  logic [wsp_pkg::VAL_W-1:0]  head_value,
    output logic [SLOT_W-1:0]          slot_out,
    output logic [wsp_pkg::VAL_W-1:0]  value_out
);
    import wsp_pkg::*;

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic              is_append;
    logic              is_tail;

    assign is_append = (CNT_W'(IDX) == len);
    assign is_tail   = (CNT_W'(IDX + 1) == len);

    always_comb begin
        slot_next  = slot_reg;
        value_next = value_reg;
        unique case (ctrl.op)
            UOP_HOLD: begin
            end
            UOP_LOAD: begin
                if (is_append) begin
                    slot_next  = load_slot;
                    value_next = ctrl.value;
                end
            end
            UOP_ROT: begin
                // The head re-enters at the tail, the rest move one place up.
                if (is_tail) begin
                    slot_next  = head_slot;
                    value_next = head_value;
                end else begin
                    slot_next  = next_slot;
                    value_next = next_value;
                end
            end
            UOP_DROP: begin
                slot_next  = next_slot;
                value_next = next_value;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        slot_reg  <= slot_next;
        value_reg <= value_next;
    end

    assign slot_out  = slot_reg;
    assign value_out = value_reg;

endmodule

// File: design/wsp_free_cell.sv
// ----------------------------------------------------------------------------
// Free stack cell
// Holds one entry of the free slot stack; cell 0 is the top. Pop moves every
// entry one place up, push moves every entry one place down.
// ----------------------------------------------------------------------------
module wsp_free_cell #(
    parameter int SLOT_W = 5,
    parameter int IDX    = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  wsp_pkg::wsp_fctl_t ctrl,
    input  logic [SLOT_W-1:0]  prev_slot,
    input  logic [SLOT_W-1:0]  next_slot,
    output logic [SLOT_W-1:0]  slot_out
);
    import wsp_pkg::*;

    logic [SLOT_W-1:0] slot_reg, slot_next;

    always_comb begin
        slot_next = slot_reg;
        unique case (ctrl.op)
            FOP_POP:  slot_next = next_slot;
            FOP_PUSH: slot_next = prev_slot;
            default:  slot_next = slot_reg;
        endcase
    end

    // After reset the stack holds every slot in ascending order from the top.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= SLOT_W'(IDX);
        end else begin
            slot_reg <= slot_next;
        end
    end

    assign slot_out = slot_reg;

endmodule

// File: design/watch_slot_pool_manager_top.sv
// ----------------------------------------------------------------------------
// Watch slot pool manager
// Fixed pool of numbered slots split between a free stack and an ordered
// in-use list, both kept in rows of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one command per transfer: allocate, delete by
//   number or list. The master channel returns the results; m_tlast marks the
//   final result of a command. Command code 3 is consumed and gives nothing.
//   Allocate: one result, issued once the output register is free.
//   Delete: the in-use ring is rotated once through all n in-use cells, one
//   cell per cycle, then the result is issued once the output register is free.
//   List: results come from the ring head, one result per cycle as the ring
//   rotates while the output register is free; n results in all, or one status
//   result when nothing is in use.
//   A new command is taken as soon as the previous one has issued its last
//   result, even while that result still waits in the output register.
//   When the receiver stalls, the output register holds its transfer and the
//   list walk pauses until it is taken; the delete walk needs no output and
//   only its final result waits.
//   Reset returns every slot to the free stack, lowest number on top, and
//   empties the in-use list.
// ----------------------------------------------------------------------------
module watch_slot_pool_manager_top #(
    parameter int POOL_SIZE = wsp_pkg::POOL_SIZE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: command[1:0], watch_number[6:2], initial_value[38:7], zero[39]
    input  logic [wsp_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // m_tdata: status[1:0], entry_number[6:2], entry_value[38:7], zero[39]
    output logic [wsp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    output logic                             m_tlast,
    input  logic                             m_tready
);
    import wsp_pkg::*;

    localparam int SLOT_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W  = $clog2(POOL_SIZE + 1);
    localparam int CMP_W  = (SLOT_W > NUM_W) ? SLOT_W : NUM_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_WALK = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_LIST = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [CNT_W-1:0]  used_cnt_reg, used_cnt_next;
    logic [CNT_W-1:0]  free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic              found_reg, found_next;
    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [NUM_W-1:0]  m_number_reg, m_number_next;
    logic [VAL_W-1:0]  m_value_reg, m_value_next;
    logic              m_last_reg, m_last_next;

    logic [SLOT_W-1:0] u_slot  [POOL_SIZE];
    logic [VAL_W-1:0]  u_value [POOL_SIZE];
    logic [SLOT_W-1:0] f_slot  [POOL_SIZE];
    wsp_uctl_t         uctl;
    wsp_fctl_t         fctl;
    logic [SLOT_W-1:0] push_slot;
    logic              out_free;
    logic              head_match;

    assign out_free   = !m_valid_reg || m_tready;
    assign head_match = (CMP_W'(u_slot[0]) == CMP_W'(num_reg));
    assign push_slot  = SLOT_W'(num_reg);

    // ------------------------------------------------------------------
    // Cell rows
    // ------------------------------------------------------------------
    for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cells
        logic [SLOT_W-1:0] u_nslot;
        logic [VAL_W-1:0]  u_nvalue;
        logic [SLOT_W-1:0] f_prev;
        logic [SLOT_W-1:0] f_next;

        if (i == POOL_SIZE - 1) begin : g_end
            assign u_nslot  = u_slot[i];
            assign u_nvalue = u_value[i];
            assign f_next   = f_slot[i];
        end else begin : g_mid
            assign u_nslot  = u_slot[i+1];
            assign u_nvalue = u_value[i+1];
            assign f_next   = f_slot[i+1];
        end

        if (i == 0) begin : g_top
            assign f_prev = push_slot;
        end else begin : g_below
            assign f_prev = f_slot[i-1];
        end

        wsp_use_cell #(
            .SLOT_W (SLOT_W),
            .CNT_W  (CNT_W),
            .IDX    (i)
        ) u_use (
            .aclk       (aclk),
            .ctrl       (uctl),
            .len        (used_cnt_reg),
            .load_slot  (f_slot[0]),
            .next_slot  (u_nslot),
            .next_value (u_nvalue),
            .head_slot  (u_slot[0]),
            .head_value (u_value[0]),
            .slot_out   (u_slot[i]),
            .value_out  (u_value[i])
        );

        wsp_free_cell #(
            .SLOT_W (SLOT_W),
            .IDX    (i)
        ) u_free (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (fctl),
            .prev_slot (f_prev),
            .next_slot (f_next),
            .slot_out  (f_slot[i])
        );
    end

    // ------------------------------------------------------------------
    // Command sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        num_next      = num_reg;
        val_next      = val_reg;
        used_cnt_next = used_cnt_reg;
        free_cnt_next = free_cnt_reg;
        step_next     = step_reg;
        found_next    = found_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_number_next = m_number_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;
        uctl.op       = UOP_HOLD;
        uctl.value    = val_reg;
        fctl.op       = FOP_HOLD;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tdata[CMD_W-1:0];
                    num_next   = s_tdata[CMD_W +: NUM_W];
                    val_next   = s_tdata[CMD_W+NUM_W +: VAL_W];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (cmd_reg)
                    CMD_ALLOC: begin
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b1;
                            if (free_cnt_reg == '0) begin
                                m_status_next = STAT_EMPTY;
                                m_number_next = '0;
                                m_value_next  = '0;
                            end else begin
                                uctl.op       = UOP_LOAD;
                                fctl.op       = FOP_POP;
                                used_cnt_next = used_cnt_reg + 1'b1;
                                free_cnt_next = free_cnt_reg - 1'b1;
                                m_status_next = STAT_OK;
                                m_number_next = NUM_W'(f_slot[0]);
                                m_value_next  = val_reg;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    CMD_DELETE: begin
                        step_next  = used_cnt_reg;
                        found_next = 1'b0;
                        state_next = (used_cnt_reg == '0) ? ST_DONE : ST_WALK;
                    end
                    CMD_LIST: begin
                        if (used_cnt_reg == '0) begin
                            if (out_free) begin
                                m_valid_next  = 1'b1;
                                m_last_next   = 1'b1;
                                m_status_next = STAT_NONE;
                                m_number_next = '0;
                                m_value_next  = '0;
                                state_next    = ST_IDLE;
                            end
                        end else begin
                            step_next  = used_cnt_reg;
                            state_next = ST_LIST;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WALK: begin
                // Every in-use entry passes the head once; a match leaves the ring.
                // The free count moves with the in-use count so both always cover
                // the pool; the slot itself is pushed when the result goes out.
                if (head_match && !found_reg) begin
                    uctl.op       = UOP_DROP;
                    used_cnt_next = used_cnt_reg - 1'b1;
                    free_cnt_next = free_cnt_reg + 1'b1;
                    found_next    = 1'b1;
                end else begin
                    uctl.op = UOP_ROT;
                end
                step_next = step_reg - 1'b1;
                if (step_reg == CNT_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_last_next   = 1'b1;
                    m_number_next = num_reg;
                    m_value_next  = '0;
                    if (found_reg) begin
                        fctl.op       = FOP_PUSH;
                        m_status_next = STAT_OK;
                    end else begin
                        m_status_next = STAT_MISSING;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    uctl.op       = UOP_ROT;
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_number_next = NUM_W'(u_slot[0]);
                    m_value_next  = u_value[0];
                    m_last_next   = (step_reg == CNT_W'(1));
                    step_next     = step_reg - 1'b1;
                    if (step_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_cnt_reg <= '0;
            free_cnt_reg <= CNT_W'(POOL_SIZE);
            step_reg     <= '0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_cnt_reg <= used_cnt_next;
            free_cnt_reg <= free_cnt_next;
            step_reg     <= step_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        num_reg      <= num_next;
        val_reg      <= val_next;
        m_status_reg <= m_status_next;
        m_number_reg <= m_number_next;
        m_value_reg  <= m_value_next;
        m_last_reg   <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_value_reg, m_number_reg, m_status_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        ((CNT_W + 1)'(used_cnt_reg) + (CNT_W + 1)'(free_cnt_reg))
            == (CNT_W + 1)'(POOL_SIZE))
        else $error("free and in-use counts do not cover the pool");

    a_list_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LIST) |-> (step_reg != '0) && (step_reg <= used_cnt_reg))
        else $error("list walk step count out of range");

    a_drop_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && head_match && !found_reg)
            |=> (used_cnt_reg == $past(used_cnt_reg) - 1'b1) && found_reg)
        else $error("matched slot not removed from the in-use ring");

    a_walk_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && step_reg == CNT_W'(1)) |=> (state_reg == ST_DONE))
        else $error("delete walk did not finish after one pass");

endmodule
